/* sv/magv_pkg.sv */
// Shared types and constants for the magnetometer validate-and-select block.
package magv_pkg;

  localparam int COMPONENT_BITS = 20;
  localparam int EXP_W   = 20;
  localparam int LIM_W   = 16;
  localparam int DEV_W   = 16;
  localparam int SUM_W   = 2 * COMPONENT_BITS + 2;
  localparam int ROOT_W  = COMPONENT_BITS + 1;
  localparam int DIFF_W  = (ROOT_W > EXP_W) ? ROOT_W : EXP_W;
  localparam int PCT_W   = 15;
  localparam int PROD_W  = DIFF_W + PCT_W;
  localparam int CNT_W   = $clog2(ROOT_W + 1);
  localparam int IN_DATA_W  = ((6 * COMPONENT_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * COMPONENT_BITS + 7) / 8) * 8;

  localparam logic [PCT_W-1:0] PERCENT_Q8 = PCT_W'(25600);
  localparam logic [2:0]       GRACE_LIMIT = 3'd5;

  typedef enum logic [1:0] {
    MODE_BOTH  = 2'd0,
    MODE_BOARD = 2'd1,
    MODE_AUX   = 2'd2
  } usage_t;

  typedef enum logic [1:0] {
    REG_USAGE    = 2'd0,
    REG_EXPECTED = 2'd1,
    REG_WARN     = 2'd2,
    REG_ERR      = 2'd3
  } reg_idx_t;

  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_BOARD = 2'd1;
  localparam logic [1:0] SRC_AUX   = 2'd2;

  localparam logic [1:0] ALARM_CLEAR = 2'd0;
  localparam logic [1:0] ALARM_WARN  = 2'd1;
  localparam logic [1:0] ALARM_CRIT  = 2'd2;

  typedef struct packed {
    logic             done;
    logic [DEV_W-1:0] dev;
  } lane_res_t;

  typedef struct packed {
    logic [1:0]       usage;
    logic [LIM_W-1:0] warn_lim;
    logic [LIM_W-1:0] err_lim;
  } grade_cfg_t;

endpackage

/* sv/magv_lane.sv */
// One deviation lane: sum of squares, bitwise square root, scaled divide.
module magv_lane (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic                                      ack,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] vx,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] vy,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] vz,
  input  logic        [magv_pkg::EXP_W-1:0]          expected,
  output magv_pkg::lane_res_t                        res
);
  import magv_pkg::*;

  typedef enum logic [6:0] {
    L_IDLE  = 7'b0000001,
    L_SQ    = 7'b0000010,
    L_ROOT  = 7'b0000100,
    L_SCALE = 7'b0001000,
    L_CHK   = 7'b0010000,
    L_DIV   = 7'b0100000,
    L_DONE  = 7'b1000000
  } lstate_t;

  localparam int REM_W = ROOT_W + 3;

  lstate_t                 st_r, st_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [2*COMPONENT_BITS-1:0] sq_r, sq_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SUM_W-1:0]        rad_r, rad_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [ROOT_W-1:0]       root_r, root_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [EXP_W-1:0]        drem_r, drem_nxt;
  logic [DEV_W-1:0]        q_r, q_nxt;

  logic signed [COMPONENT_BITS-1:0] comp;
  logic [COMPONENT_BITS-1:0] mag;
  logic [REM_W-1:0]  rem_sh, trial;
  logic [DIFF_W-1:0] root_x, exp_x, diff;
  logic [EXP_W:0]    dtrial;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    comp = vx;
      2'd1:    comp = vy;
      default: comp = vz;
    endcase
    mag    = comp[COMPONENT_BITS-1] ? (~comp + 1'b1) : comp;
    rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
    root_x = DIFF_W'(root_r);
    exp_x  = DIFF_W'(expected);
    diff   = (root_x > exp_x) ? (root_x - exp_x) : (exp_x - root_x);
    dtrial = {drem_r, prod_r[DEV_W-1]};
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    sq_nxt   = sq_r;
    sum_nxt  = sum_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    prod_nxt = prod_r;
    drem_nxt = drem_r;
    q_nxt    = q_r;
    case (st_r)
      L_IDLE: begin
        if (start) begin
          st_nxt  = L_SQ;
          cnt_nxt = '0;
          sq_nxt  = '0;
          sum_nxt = '0;
        end
      end
      L_SQ: begin
        sq_nxt  = (cnt_r < CNT_W'(3)) ? (mag * mag) : '0;
        sum_nxt = sum_r + SUM_W'(sq_r);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          rad_nxt  = sum_r + SUM_W'(sq_r);
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = '0;
          st_nxt   = L_ROOT;
        end
      end
      L_ROOT: begin
        // two radicand bits in, one root bit out
        rad_nxt = {rad_r[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          st_nxt = L_SCALE;
        end
      end
      L_SCALE: begin
        prod_nxt = PROD_W'(diff * PERCENT_Q8);
        st_nxt   = L_CHK;
      end
      L_CHK: begin
        // quotient overflows 16 bits (or zero divisor): saturate
        if (DIFF_W'(prod_r[PROD_W-1:DEV_W]) >= exp_x) begin
          q_nxt  = '1;
          st_nxt = L_DONE;
        end else begin
          drem_nxt = prod_r[DEV_W +: EXP_W];
          q_nxt    = '0;
          cnt_nxt  = '0;
          st_nxt   = L_DIV;
        end
      end
      L_DIV: begin
        prod_nxt = {prod_r[PROD_W-1:DEV_W], prod_r[DEV_W-2:0], 1'b0};
        if (dtrial >= {1'b0, expected}) begin
          drem_nxt = EXP_W'(dtrial - {1'b0, expected});
          q_nxt    = {q_r[DEV_W-2:0], 1'b1};
        end else begin
          drem_nxt = EXP_W'(dtrial);
          q_nxt    = {q_r[DEV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DEV_W - 1)) begin
          st_nxt = L_DONE;
        end
      end
      L_DONE: begin
        if (ack) begin
          st_nxt = L_IDLE;
        end
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= L_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    sq_r   <= sq_nxt;
    sum_r  <= sum_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    prod_r <= prod_nxt;
    drem_r <= drem_nxt;
    q_r    <= q_nxt;
  end

  assign res.done = (st_r == L_DONE);
  assign res.dev  = q_r;

endmodule

/* sv/magv_merge.sv */
// Merge stage: grading, grace counters, alarm, source selection, result register.
module magv_merge (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  magv_pkg::grade_cfg_t                       cfg,
  input  magv_pkg::lane_res_t                        aux_res,
  input  magv_pkg::lane_res_t                        brd_res,
  input  logic                                      aux_p,
  input  logic                                      brd_p,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] ax,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] ay,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] az,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] bx,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] by,
  input  logic signed [magv_pkg::COMPONENT_BITS-1:0] bz,
  output logic                                      fire,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic        [3*magv_pkg::COMPONENT_BITS-1:0] out_vec,
  output logic        [1:0]                          out_status,
  output logic        [1:0]                          out_alarm
);
  import magv_pkg::*;

  localparam int CB = COMPONENT_BITS;

  typedef struct packed {
    logic       ok;
    logic [2:0] wc;
    logic [2:0] ec;
    logic [1:0] al;
  } gstate_t;

  function automatic gstate_t grade(input logic [DEV_W-1:0] dev, input logic alarms,
                                    input gstate_t s, input grade_cfg_t c);
    gstate_t r;
    r    = s;
    r.ok = 1'b1;
    if (dev < c.warn_lim) begin
      r.wc = '0;
      r.ec = '0;
      r.al = ALARM_CLEAR;
    end else if (dev < c.err_lim) begin
      r.ec = '0;
      if (s.wc > GRACE_LIMIT) begin
        r.ok = 1'b0;
        if (alarms) r.al = ALARM_WARN;
      end else begin
        r.wc = s.wc + 3'd1;
      end
    end else begin
      if (s.ec > GRACE_LIMIT) begin
        r.ok = 1'b0;
        if (alarms) r.al = ALARM_CRIT;
      end else begin
        r.ec = s.ec + 3'd1;
      end
    end
    return r;
  endfunction

  logic [2:0] wc_r, ec_r;
  logic [1:0] al_r;
  logic       vld_r;
  logic [3*CB-1:0] vec_r;
  logic [1:0] st_r;

  gstate_t s0, s1, s2, g1, g2;
  logic aux_only, brd_only, aux_use, brd_use, aux_acc, brd_acc, none;
  logic signed [CB:0] sx, sy, sz;
  logic signed [CB-1:0] mx, my, mz;
  logic [1:0] status;

  always_comb begin
    aux_only = (cfg.usage == MODE_AUX);
    brd_only = (cfg.usage == MODE_BOARD);
    aux_use  = !brd_only && aux_p;
    brd_use  = !aux_only && brd_p;
    s0 = '{ok: 1'b1, wc: wc_r, ec: ec_r, al: al_r};
    g1 = grade(aux_res.dev, aux_only, s0, cfg);
    s1 = aux_use ? g1 : s0;
    aux_acc = aux_use && (g1.ok || aux_only);
    none = !aux_acc;
    g2 = grade(brd_res.dev, none, s1, cfg);
    s2 = brd_use ? g2 : s1;
    brd_acc = brd_use && (g2.ok || none);
    sx = (aux_acc ? (CB+1)'(ax) : '0) + (brd_acc ? (CB+1)'(bx) : '0);
    sy = (aux_acc ? (CB+1)'(ay) : '0) + (brd_acc ? (CB+1)'(by) : '0);
    sz = (aux_acc ? (CB+1)'(az) : '0) + (brd_acc ? (CB+1)'(bz) : '0);
    if (aux_acc && brd_acc) begin
      mx = sx[CB:1];
      my = sy[CB:1];
      mz = sz[CB:1];
    end else begin
      mx = sx[CB-1:0];
      my = sy[CB-1:0];
      mz = sz[CB-1:0];
    end
    if (brd_acc)      status = SRC_BOARD;
    else if (aux_acc) status = SRC_AUX;
    else              status = SRC_NONE;
  end

  assign fire = aux_res.done && brd_res.done && (!vld_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r  <= '0;
      ec_r  <= '0;
      al_r  <= ALARM_CLEAR;
      vld_r <= 1'b0;
    end else begin
      if (fire) begin
        wc_r  <= s2.wc;
        ec_r  <= s2.ec;
        al_r  <= s2.al;
        vld_r <= 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
    if (fire) begin
      vec_r <= {mz, my, mx};
      st_r  <= status;
    end
  end

  assign out_valid  = vld_r;
  assign out_vec    = vec_r;
  assign out_status = st_r;
  assign out_alarm  = al_r;

endmodule

/* sv/magnetometer_validate_select.sv */
// Top level: magnetometer validation and source selection with two deviation lanes.
//
//  channel | direction | tdata (low bit up)                     | tuser (low bit up)
//  in_     | slave     | aux_x, aux_y, aux_z, board_x/y/z        | aux_present, board_present
//  out_    | master    | mag_x, mag_y, mag_z, 4 zero pad bits    | source_status, alarm_level
//  cfg_    | write     | index 0..3, 20-bit data                 | -
//
// One item at a time: a transfer is taken only while both lanes are idle.
// Each item runs through the lane sequencer from input transfer to result register:
// sum of squares, 21 square-root steps, scale and saturation check, 16 divide
// steps, then the merge into the result register (a saturated quotient skips the divide).
// Both lanes start together; the merge waits for the slower one and grades aux first.
// Reset (rst_n low, synchronous) clears counters, alarm and valid flags and
// reloads register defaults. A stalled result waits in the output register while
// the next item is already taken and worked on.
module magnetometer_validate_select (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [magv_pkg::IN_DATA_W-1:0]          in_tdata,  // aux_x,aux_y,aux_z,board_x,y,z
  input  logic [1:0]                              in_tuser,  // aux_present, board_present
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [magv_pkg::OUT_DATA_W-1:0]         out_tdata, // mag_x, mag_y, mag_z
  output logic [3:0]                              out_tuser, // source_status, alarm_level
  input  logic                                    cfg_we,
  input  logic [1:0]                              cfg_addr,
  input  logic [magv_pkg::EXP_W-1:0]              cfg_wdata
);
  import magv_pkg::*;

  localparam int CB = COMPONENT_BITS;

  // configuration registers
  logic [1:0]       usage_r;
  logic [EXP_W-1:0] exp_r;
  logic [LIM_W-1:0] warn_r, err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usage_r <= MODE_BOTH;
      exp_r   <= '1;
      warn_r  <= LIM_W'(1280);
      err_r   <= LIM_W'(2560);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_USAGE:    usage_r <= cfg_wdata[1:0];
        REG_EXPECTED: exp_r   <= cfg_wdata;
        REG_WARN:     warn_r  <= cfg_wdata[LIM_W-1:0];
        REG_ERR:      err_r   <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // item holding registers, stable while the lanes work
  logic            busy_r;
  logic [6*CB-1:0] item_r;
  logic [1:0]      pres_r;
  logic            in_xfer, fire;

  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
    end else if (fire) begin
      busy_r <= 1'b0;
    end
    if (in_xfer) begin
      item_r <= in_tdata[6*CB-1:0];
      pres_r <= in_tuser;
    end
  end

  lane_res_t  aux_res, brd_res;
  grade_cfg_t gcfg;
  logic [3*CB-1:0] vec;
  logic [1:0] status, alarm;

  assign gcfg = '{usage: usage_r, warn_lim: warn_r, err_lim: err_r};

  magv_lane u_aux (
    .clk(clk), .rst_n(rst_n), .start(in_xfer), .ack(fire),
    .vx(item_r[0*CB +: CB]), .vy(item_r[1*CB +: CB]), .vz(item_r[2*CB +: CB]),
    .expected(exp_r), .res(aux_res)
  );

  magv_lane u_brd (
    .clk(clk), .rst_n(rst_n), .start(in_xfer), .ack(fire),
    .vx(item_r[3*CB +: CB]), .vy(item_r[4*CB +: CB]), .vz(item_r[5*CB +: CB]),
    .expected(exp_r), .res(brd_res)
  );

  magv_merge u_merge (
    .clk(clk), .rst_n(rst_n), .cfg(gcfg), .aux_res(aux_res), .brd_res(brd_res),
    .aux_p(pres_r[0]), .brd_p(pres_r[1]),
    .ax(item_r[0*CB +: CB]), .ay(item_r[1*CB +: CB]), .az(item_r[2*CB +: CB]),
    .bx(item_r[3*CB +: CB]), .by(item_r[4*CB +: CB]), .bz(item_r[5*CB +: CB]),
    .fire(fire), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_vec(vec), .out_status(status), .out_alarm(alarm)
  );

  assign out_tdata = OUT_DATA_W'(vec);
  assign out_tuser = {alarm, status};

`ifndef ASSERT_OFF
  a_lane_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (aux_res.done || brd_res.done) |-> busy_r) else $error("lane finished without item");
  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid) else $error("result lost after merge");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status == SRC_NONE) |-> (vec == '0)) else $error("invalid result not zero");
  a_alarm_code: assert property (@(posedge clk) disable iff (!rst_n)
    alarm <= ALARM_CRIT) else $error("bad alarm level");
  a_busy_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> busy_r) else $error("merge without item");
`endif

endmodule
